// File: rtl/core/mep_pkg.sv
package mep_pkg;
   localparam int MAX_DIMENSION = 4096;
   localparam int FRACTION_BITS = 24;
   localparam int COUNT_BITS    = 16;
   localparam int DIM_CFG_BITS  = 13;
   localparam int LIM_CFG_BITS  = 16;
   localparam int IDX_BITS      = 12;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int GRAY_BITS     = 8;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LIMIT  = 2'd2;

   localparam logic [DIM_CFG_BITS-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [DIM_CFG_BITS-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [LIM_CFG_BITS-1:0] LIMIT_RESET  = 16'd256;
endpackage

// File: rtl/core/mandelbrot_escape_pixel.sv
// Mapping runs two serial divisions in the front end, then the point passes the queue;
// each iteration is a squarer stage then an update (an escape costs one more pair),
// then a serial divide gives the gray level.
// The back end takes a new point only when it is done with the last; the front end maps
// the next pixel meanwhile and hands it over through a two-entry queue.
// Synchronous active-high reset: empty pipeline, registers 640, 480, 256.
module mandelbrot_escape_pixel #(
   parameter int MAX_DIMENSION = mep_pkg::MAX_DIMENSION,
   parameter int FRACTION_BITS = mep_pkg::FRACTION_BITS,
   parameter int COUNT_BITS    = mep_pkg::COUNT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,   // pixel_row, pixel_column
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [COUNT_BITS+7:0]             rsp_tdata,   // iteration_count, gray_level
   input  logic                              csr_wen,
   input  logic [mep_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [mep_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   localparam int DATA_BITS = FRACTION_BITS + 8;

   logic [mep_pkg::DIM_CFG_BITS-1:0] width_ff, height_ff;
   logic [mep_pkg::LIM_CFG_BITS-1:0] limit_ff;
   logic                   f_valid, f_ready, q_valid, q_ready;
   logic [2*DATA_BITS-1:0] f_c, q_c;
   logic [COUNT_BITS-1:0]  cnt;
   logic [7:0]             gray;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= mep_pkg::WIDTH_RESET;
         height_ff <= mep_pkg::HEIGHT_RESET;
         limit_ff  <= mep_pkg::LIMIT_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            mep_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[mep_pkg::DIM_CFG_BITS-1:0];
            mep_pkg::CSR_HEIGHT: height_ff <= csr_wdata[mep_pkg::DIM_CFG_BITS-1:0];
            mep_pkg::CSR_LIMIT:  limit_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   mep_front #(.MAX_DIMENSION(MAX_DIMENSION), .FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_row     (req_tdata[11:0]),
      .in_col     (req_tdata[23:12]),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .out_valid  (f_valid),
      .out_ready  (f_ready),
      .out_c      (f_c)
   );

   mep_queue #(.WIDTH(2*DATA_BITS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_c),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_c)
   );

   mep_back #(.FRACTION_BITS(FRACTION_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_c      (q_c),
      .cfg_limit (limit_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_count (cnt),
      .out_gray  (gray)
   );

   assign rsp_tdata = {gray, cnt};
endmodule

// File: rtl/core/mep_divider.sv
// Restoring divider: quo = num / den, one quotient bit per cycle.
module mep_divider #(
   parameter int NUM_BITS = 40,
   parameter int DEN_BITS = 17
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic                done,
   output logic [NUM_BITS-1:0] quo
);
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] q_ff, q_in;
   logic [DEN_BITS:0]   r_ff, r_in;
   logic [DEN_BITS-1:0] d_ff, d_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_BITS:0]   trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff[DEN_BITS-1:0], q_ff[NUM_BITS-1]};
      if (start) begin
         q_in    = num;
         r_in    = '0;
         d_in    = den;
         cnt_in  = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

// File: rtl/core/mep_front.sv
// Saturates the pixel and maps it to c with two serial divisions.
module mep_front #(
   parameter int MAX_DIMENSION = mep_pkg::MAX_DIMENSION,
   parameter int FRACTION_BITS = mep_pkg::FRACTION_BITS,
   parameter int DATA_BITS     = FRACTION_BITS + 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic [mep_pkg::IDX_BITS-1:0]         in_row,
   input  logic [mep_pkg::IDX_BITS-1:0]         in_col,
   input  logic [mep_pkg::DIM_CFG_BITS-1:0]     cfg_width,
   input  logic [mep_pkg::DIM_CFG_BITS-1:0]     cfg_height,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [2*DATA_BITS-1:0]               out_c
);
   localparam int DIM_BITS = $clog2(MAX_DIMENSION + 1);
   localparam int NUM_BITS = mep_pkg::IDX_BITS + 2 + FRACTION_BITS;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_COL  = 4'b0010,
      ST_ROW  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type st_ff, st_in;
   logic [DIM_BITS-1:0]    wd, hd;
   logic [DIM_BITS-1:0]    den_h_ff, den_h_in;
   logic [DIM_BITS-1:0]    row_s, col_s;
   logic [NUM_BITS-1:0]    num_r_ff, num_r_in;
   logic [DATA_BITS-1:0]   cr_ff, cr_in, ci_ff, ci_in;
   logic                   div_start;
   logic [NUM_BITS-1:0]    div_num;
   logic [DIM_BITS-1:0]    div_den;
   logic                   div_done;
   logic [NUM_BITS-1:0]    div_quo;

   function automatic logic [DIM_BITS-1:0] clamp_dim(
      input logic [mep_pkg::DIM_CFG_BITS-1:0] d);
      logic [DIM_BITS-1:0] r;
      if (d < 2) r = DIM_BITS'(2);
      else if ({19'd0, d} > 32'(MAX_DIMENSION)) r = DIM_BITS'(MAX_DIMENSION);
      else r = DIM_BITS'(d);
      return r;
   endfunction

   always_comb begin
      wd    = clamp_dim(cfg_width);
      hd    = clamp_dim(cfg_height);
      row_s = DIM_BITS'(in_row);
      col_s = DIM_BITS'(in_col);
      if ({20'd0, in_row} > 32'(hd - 1'b1)) row_s = hd - 1'b1;
      if ({20'd0, in_col} > 32'(wd - 1'b1)) col_s = wd - 1'b1;
   end

   always_comb begin
      st_in     = st_ff;
      den_h_in  = den_h_ff;
      num_r_in  = num_r_ff;
      cr_in     = cr_ff;
      ci_in     = ci_ff;
      div_start = 1'b0;
      div_num   = NUM_BITS'(col_s) * NUM_BITS'(3) << FRACTION_BITS;
      div_den   = wd - 1'b1;
      case (st_ff)
         ST_IDLE: begin
            if (in_valid) begin
               div_start = 1'b1;
               den_h_in  = hd - 1'b1;
               num_r_in  = NUM_BITS'(row_s) * NUM_BITS'(3) << FRACTION_BITS;
               st_in     = ST_COL;
            end
         end
         ST_COL: begin
            div_num = num_r_ff;
            div_den = den_h_ff;
            if (div_done) begin
               cr_in     = DATA_BITS'(div_quo) - (DATA_BITS'(2) << FRACTION_BITS);
               div_start = 1'b1;
               st_in     = ST_ROW;
            end
         end
         ST_ROW: begin
            if (div_done) begin
               ci_in = DATA_BITS'(div_quo) - (DATA_BITS'(3) << (FRACTION_BITS - 1));
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else       st_ff <= st_in;
      den_h_ff <= den_h_in;
      num_r_ff <= num_r_in;
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
   end

   mep_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DIM_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign in_ready  = (st_ff == ST_IDLE);
   assign out_valid = (st_ff == ST_OUT);
   assign out_c     = {ci_ff, cr_ff};
endmodule

// File: rtl/core/mep_queue.sv
// Two-entry queue of mapped points between front and back.
module mep_queue #(
   parameter int WIDTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic [WIDTH-1:0] mem_in [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rp_ff];

   always_comb begin
      mem_in = mem_ff;
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      if (push) begin
         mem_in[wp_ff] = in_data;
         wp_in         = ~wp_ff;
      end
      if (pop) rp_in = ~rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      mem_ff <= mem_in;
   end
endmodule

// File: rtl/core/mep_back.sv
// Escape-time iteration, then gray = count*255/limit on a serial divider.
// Each iteration forms the squares and cross product, then updates and tests.
module mep_back #(
   parameter int FRACTION_BITS = mep_pkg::FRACTION_BITS,
   parameter int COUNT_BITS    = mep_pkg::COUNT_BITS,
   parameter int DATA_BITS     = FRACTION_BITS + 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [2*DATA_BITS-1:0]           in_c,
   input  logic [mep_pkg::LIM_CFG_BITS-1:0] cfg_limit,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [COUNT_BITS-1:0]            out_count,
   output logic [mep_pkg::GRAY_BITS-1:0]    out_gray
);
   localparam int PROD_BITS = 2 * DATA_BITS;
   localparam int NUM_BITS  = COUNT_BITS + 8;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_UPD  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type st_ff, st_in;
   logic signed [DATA_BITS-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic signed [DATA_BITS-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [DATA_BITS-1:0] zr2_ff, zr2_in, zi2_ff, zi2_in, zx_ff, zx_in;
   logic [COUNT_BITS-1:0]       cnt_ff, cnt_in, lim_ff, lim_in;
   logic [mep_pkg::GRAY_BITS-1:0] gray_ff, gray_in;
   logic signed [PROD_BITS-1:0] p_rr, p_ii, p_ri;
   logic signed [DATA_BITS-1:0] mag;
   logic [COUNT_BITS-1:0]       lim_c;
   logic                        div_start, div_done;
   logic [NUM_BITS-1:0]         div_quo;

   always_comb begin
      if (cfg_limit == '0) lim_c = COUNT_BITS'(1);
      else if ({8'd0, cfg_limit} > 24'((1 << COUNT_BITS) - 1))
         lim_c = COUNT_BITS'((1 << COUNT_BITS) - 1);
      else lim_c = COUNT_BITS'(cfg_limit);
   end

   assign p_rr = PROD_BITS'(zr_ff) * PROD_BITS'(zr_ff);
   assign p_ii = PROD_BITS'(zi_ff) * PROD_BITS'(zi_ff);
   assign p_ri = PROD_BITS'($signed({zr_ff[DATA_BITS-2:0], 1'b0})) * PROD_BITS'(zi_ff);
   assign mag  = zr2_ff + zi2_ff;

   always_comb begin
      st_in     = st_ff;
      cr_in     = cr_ff;
      ci_in     = ci_ff;
      zr_in     = zr_ff;
      zi_in     = zi_ff;
      zr2_in    = DATA_BITS'(p_rr >>> FRACTION_BITS);
      zi2_in    = DATA_BITS'(p_ii >>> FRACTION_BITS);
      zx_in     = DATA_BITS'(p_ri >>> FRACTION_BITS);
      cnt_in    = cnt_ff;
      lim_in    = lim_ff;
      gray_in   = gray_ff;
      div_start = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (in_valid) begin
               cr_in  = in_c[DATA_BITS-1:0];
               ci_in  = in_c[2*DATA_BITS-1:DATA_BITS];
               zr_in  = '0;
               zi_in  = '0;
               cnt_in = '0;
               lim_in = lim_c;
               st_in  = ST_MUL;
            end
         end
         ST_MUL: st_in = ST_UPD;
         ST_UPD: begin
            if (mag > ($signed(DATA_BITS'(4)) <<< FRACTION_BITS)) begin
               div_start = 1'b1;
               st_in     = ST_DIV;
            end else begin
               zr_in  = zr2_ff - zi2_ff + cr_ff;
               zi_in  = zx_ff + ci_ff;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff + 1'b1 == lim_ff) begin
                  div_start = 1'b1;
                  st_in     = ST_DIV;
               end else begin
                  st_in = ST_MUL;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               gray_in = mep_pkg::GRAY_BITS'(div_quo);
               st_in   = ST_OUT;
            end
         end
         ST_OUT: if (out_ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else       st_ff <= st_in;
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
      zr_ff   <= zr_in;
      zi_ff   <= zi_in;
      zr2_ff  <= zr2_in;
      zi2_ff  <= zi2_in;
      zx_ff   <= zx_in;
      cnt_ff  <= cnt_in;
      lim_ff  <= lim_in;
      gray_ff <= gray_in;
   end

   mep_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(COUNT_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({cnt_in, 8'd0} - NUM_BITS'(cnt_in)),
      .den   (lim_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign in_ready  = (st_ff == ST_IDLE);
   assign out_valid = (st_ff == ST_OUT);
   assign out_count = cnt_ff;
   assign out_gray  = gray_ff;
endmodule
